// File: rtl/codeword_lexicographic_rank_macros.svh
// Assertion macros for the codeword rank block.
`ifndef CODEWORD_LEXICOGRAPHIC_RANK_MACROS_SVH
`define CODEWORD_LEXICOGRAPHIC_RANK_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CWLR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cwlr assertion failed");
// Check that a condition implies another one on the next edge.
`define CWLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwlr next-cycle assertion failed");
`else
`define CWLR_ASSERT(label, prop)
`define CWLR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/cwlr_pkg.sv
// Types, constants and the weight table of the codeword rank block.
`default_nettype none
package cwlr_pkg;

  localparam int MAX_PEGS    = 6;
  localparam int MAX_COLORS  = 10;
  localparam int INPUT_PEGS  = 6;
  localparam int COLOR_W     = 4;
  localparam int RANK_W      = 20;
  localparam int PEG_CNT_W   = 3;
  localparam int MASK_W      = 2 ** COLOR_W;
  localparam int CNT_W       = $clog2(INPUT_PEGS);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int S_TDATA_W   = ((INPUT_PEGS * COLOR_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((RANK_W + 7) / 8) * 8;
  localparam int WTAB_IDX_W  = 1 + PEG_CNT_W + COLOR_W;
  localparam int WTAB_DEPTH  = 2 ** WTAB_IDX_W;

  typedef logic [COLOR_W-1:0]                    color_t;
  typedef logic [PEG_CNT_W-1:0]                  peg_cnt_t;
  typedef logic [RANK_W-1:0]                     rank_t;
  typedef logic [INPUT_PEGS-1:0][COLOR_W-1:0]    peg_set_t;
  typedef logic [INPUT_PEGS-1:0][RANK_W-1:0]     weight_set_t;
  typedef weight_set_t [WTAB_DEPTH-1:0]          weight_tab_t;
  typedef logic [WTAB_IDX_W-1:0]                 wtab_idx_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOW_REPEATS = 2'd0,
    CFG_PEG_COUNT     = 2'd1,
    CFG_COLOR_COUNT   = 2'd2
  } cfg_index_t;

  localparam logic     RST_ALLOW_REPEATS = 1'b1;
  localparam peg_cnt_t RST_PEG_COUNT     = peg_cnt_t'(4);
  localparam color_t   RST_COLOR_COUNT   = color_t'(6);

  // Table address of one configuration
  function automatic wtab_idx_t weight_tab_index(logic rep, peg_cnt_t pegs, color_t colors);
    return {rep, pegs, colors};
  endfunction

  // Per-peg weights for every configuration; unused pegs get weight zero.
  function automatic weight_tab_t build_weight_tab();
    weight_tab_t tab;
    int          pegs;
    int          cols;
    rank_t       w;
    rank_t       factor;
    tab = '0;
    for (int idx = 0; idx < WTAB_DEPTH; idx++) begin
      pegs = (idx >> COLOR_W) & (2 ** PEG_CNT_W - 1);
      cols = idx & (2 ** COLOR_W - 1);
      if (pegs > MAX_PEGS) pegs = MAX_PEGS;
      if (pegs > INPUT_PEGS) pegs = INPUT_PEGS;
      if (cols > MAX_COLORS) cols = MAX_COLORS;
      w = rank_t'(1);
      for (int i = INPUT_PEGS - 1; i >= 0; i--) begin
        if (i < pegs) begin
          tab[idx][i] = w;
          if (((idx >> (WTAB_IDX_W - 1)) & 1) != 0) factor = rank_t'(cols);
          else factor = rank_t'(cols - i);
          w = rank_t'(w * factor);
        end
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT_TAB = build_weight_tab();

endpackage
`default_nettype wire

// File: rtl/cwlr_digit_unit.sv
// Per-peg rank digits: plain colors, or colors lowered by smaller colors already used.
`default_nettype none
module cwlr_digit_unit (
  input  logic               allow_repeats,
  input  cwlr_pkg::peg_set_t colors,
  output cwlr_pkg::peg_set_t digits
);
  import cwlr_pkg::*;

  // Walk the pegs in order, tracking the used-color mask
  always_comb begin
    logic [MASK_W-1:0] used;
    logic [MASK_W-1:0] below;
    logic [CNT_W-1:0]  cnt;
    used   = '0;
    digits = '0;
    for (int i = 0; i < INPUT_PEGS; i++) begin
      below = (MASK_W'(1) << colors[i]) - MASK_W'(1);
      cnt   = CNT_W'($countones(used & below));
      if (allow_repeats) begin
        digits[i] = colors[i];
      end else begin
        digits[i] = colors[i] - COLOR_W'(cnt);
      end
      used = used | (MASK_W'(1) << colors[i]);
    end
  end

endmodule
`default_nettype wire

// File: rtl/codeword_lexicographic_rank.sv
// Each codeword passes through the input, product and output registers, in that order.
// Throughput: one codeword per cycle; each stage advances when the next one is free.
// Peg weights come from a constant table and are latched on every configuration write.
// Reset (rst, synchronous): empties the pipeline, loads allow_repeats=1, peg_count=4,
// color_count=6 and the matching weights.
`default_nettype none
`include "codeword_lexicographic_rank_macros.svh"
module codeword_lexicographic_rank (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // peg0_color[3:0], peg1_color[7:4], ..., peg5_color[23:20]
  input  logic [cwlr_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // rank[19:0], zero pad above
  output logic [cwlr_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  logic [cwlr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwlr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cwlr_pkg::*;

  logic        allow_repeats, allow_repeats_next;
  peg_cnt_t    peg_count, peg_count_next;
  color_t      color_count, color_count_next;
  weight_set_t weights;

  logic        in_valid;
  peg_set_t    pegs_q;
  logic        prod_valid;
  weight_set_t prod, prod_next;
  logic        out_valid;
  rank_t       rank_q, rank_next;
  peg_set_t    digits;
  logic        prod_ready;
  logic        out_ready;

  // Decode configuration writes
  always_comb begin
    allow_repeats_next = allow_repeats;
    peg_count_next     = peg_count;
    color_count_next   = color_count;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ALLOW_REPEATS: allow_repeats_next = cfg_data[0];
        CFG_PEG_COUNT:     peg_count_next     = cfg_data[PEG_CNT_W-1:0];
        CFG_COLOR_COUNT:   color_count_next   = cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold configuration and its weights
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_repeats <= RST_ALLOW_REPEATS;
      peg_count     <= RST_PEG_COUNT;
      color_count   <= RST_COLOR_COUNT;
      weights       <= WEIGHT_TAB[weight_tab_index(RST_ALLOW_REPEATS, RST_PEG_COUNT,
                                                   RST_COLOR_COUNT)];
    end else begin
      allow_repeats <= allow_repeats_next;
      peg_count     <= peg_count_next;
      color_count   <= color_count_next;
      weights       <= WEIGHT_TAB[weight_tab_index(allow_repeats_next, peg_count_next,
                                                   color_count_next)];
    end
  end

  // Stage readiness, from the output back
  assign out_ready  = !out_valid || m_tready;
  assign prod_ready = !prod_valid || out_ready;
  assign s_tready   = !in_valid || prod_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      pegs_q <= s_tdata[INPUT_PEGS*COLOR_W-1:0];
    end
  end

  cwlr_digit_unit u_digits (
    .allow_repeats (allow_repeats),
    .colors        (pegs_q),
    .digits        (digits)
  );

  // Weight each digit
  always_comb begin
    for (int i = 0; i < INPUT_PEGS; i++) begin
      prod_next[i] = rank_t'(weights[i] * rank_t'(digits[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      prod <= prod_next;
    end
  end

  // Sum the weighted digits, wrapping to the rank width
  always_comb begin
    rank_next = '0;
    for (int i = 0; i < INPUT_PEGS; i++) begin
      rank_next = rank_next + prod[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      rank_q <= rank_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(rank_q);

  // Checks
  `CWLR_ASSERT(a_weights_match_cfg, weights == WEIGHT_TAB[weight_tab_index(allow_repeats, peg_count, color_count)])
  `CWLR_ASSERT_NEXT(a_in_holds_on_stall, in_valid && !prod_ready, in_valid)
  `CWLR_ASSERT_NEXT(a_prod_moves_to_out, prod_valid && out_ready, out_valid)
  `CWLR_ASSERT(a_ready_when_empty, !in_valid |-> s_tready)

endmodule
`default_nettype wire
